/* sv/bed_pkg.sv */
// shared types and constants for the binlog entry deframer
`timescale 1ns / 1ps

package bed_pkg;

    typedef enum logic [2:0] {
        PH_OP,
        PH_SRV,
        PH_TIME,
        PH_KLEN,
        PH_KEY,
        PH_VLEN,
        PH_VAL
    } phase_t;

    localparam logic [2:0] KIND_HDR  = 3'd0;
    localparam logic [2:0] KIND_KEY  = 3'd1;
    localparam logic [2:0] KIND_VLEN = 3'd2;
    localparam logic [2:0] KIND_VAL  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_TUSER_W = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  op_code;
        logic [31:0] server_ident;
        logic [31:0] exec_stamp;
        logic [31:0] length_value;
        logic [7:0]  payload_byte;
        logic        entry_end;
        logic        record_end;
    } result_t;

    // one queue entry: the byte's own result and/or a truncation error after it
    typedef struct packed {
        logic    has_main;
        logic    has_err;
        result_t main_res;
    } cmd_t;

endpackage

/* sv/binlog_entry_deframer_top.sv */
// top level of the binlog entry deframer
`timescale 1ns / 1ps

// Takes one record byte per cycle while the command queue is not full and splits it into
// binlog entries: a header word once the key length is in, a word per key byte, a
// value-length word and a word per value byte. A byte that ends a record mid-entry yields
// its own word (if any) and then a truncation error word, so one byte can yield two output
// words; the command queue of QUEUE_DEPTH entries between parser and output stage absorbs
// that. Sustained rate is one byte per cycle with the output ready; a word is presented
// once its byte's command, written into the queue at the accepting edge, has moved on
// into the output register.

module binlog_entry_deframer_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bed_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tlast,  // record_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] op_code, [39:8] server_ident, [71:40] exec_stamp,
    // [103:72] length_value, [111:104] payload_byte
    output logic [bed_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [bed_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // [2:0] kind, [3] entry_end
    output logic                              m_axis_tlast   // record_end
);

    logic          full;
    logic          not_empty;
    logic          push;
    logic          pop;
    bed_pkg::cmd_t push_cmd;
    bed_pkg::cmd_t head_cmd;

    bed_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .queue_full  (full),
        .data_byte   (s_axis_tdata),
        .record_last (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    bed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    bed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head_cmd  (head_cmd),
        .out_ready (m_axis_tready),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

/* sv/bed_front.sv */
// front end: byte parser that classifies each byte into queued commands
`timescale 1ns / 1ps

module bed_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                queue_full,
    input  logic [7:0]          data_byte,
    input  logic                record_last,
    output logic                in_ready,
    output logic                push,
    output bed_pkg::cmd_t       push_cmd
);

    bed_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [31:0]     asm_reg, asm_next;
    logic [31:0]     rem_reg, rem_next;
    logic [7:0]      held_op_reg, held_op_next;
    logic [31:0]     held_srv_reg, held_srv_next;
    logic [31:0]     held_time_reg, held_time_next;
    logic            accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bed_pkg::PH_OP;
            cnt_reg       <= 2'd0;
            asm_reg       <= 32'd0;
            rem_reg       <= 32'd0;
            held_op_reg   <= 8'd0;
            held_srv_reg  <= 32'd0;
            held_time_reg <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            asm_reg       <= asm_next;
            rem_reg       <= rem_next;
            held_op_reg   <= held_op_next;
            held_srv_reg  <= held_srv_next;
            held_time_reg <= held_time_next;
        end
    end

    always_comb
    begin
        logic        is_field;
        logic        full;
        logic        done;
        logic [31:0] word;
        logic [31:0] rem_dec;

        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        asm_next       = asm_reg;
        rem_next       = rem_reg;
        held_op_next   = held_op_reg;
        held_srv_next  = held_srv_reg;
        held_time_next = held_time_reg;
        push_cmd       = '0;
        full           = 1'b0;
        done           = 1'b0;
        word           = 32'd0;
        rem_dec        = rem_reg - 32'd1;

        is_field = (phase_reg == bed_pkg::PH_SRV) || (phase_reg == bed_pkg::PH_TIME) ||
                   (phase_reg == bed_pkg::PH_KLEN) || (phase_reg == bed_pkg::PH_VLEN);

        // little-endian assembly of 32-bit fields
        if (is_field)
        begin
            if (cnt_reg == 2'd3)
            begin
                full     = 1'b1;
                word     = asm_reg | {data_byte, 24'd0};
                asm_next = 32'd0;
                cnt_next = 2'd0;
            end
            else
            begin
                asm_next = asm_reg | ({24'd0, data_byte} << {cnt_reg, 3'b000});
                cnt_next = cnt_reg + 2'd1;
            end
        end

        case (phase_reg)
            bed_pkg::PH_SRV:
            begin
                if (full)
                begin
                    held_srv_next = word;
                    phase_next    = bed_pkg::PH_TIME;
                end
            end
            bed_pkg::PH_TIME:
            begin
                if (full)
                begin
                    held_time_next = word;
                    phase_next     = bed_pkg::PH_KLEN;
                end
            end
            bed_pkg::PH_KLEN:
            begin
                if (full)
                begin
                    push_cmd.has_main              = 1'b1;
                    push_cmd.main_res.kind         = bed_pkg::KIND_HDR;
                    push_cmd.main_res.op_code      = held_op_reg;
                    push_cmd.main_res.server_ident = held_srv_reg;
                    push_cmd.main_res.exec_stamp   = held_time_reg;
                    push_cmd.main_res.length_value = word;
                    rem_next                       = word;
                    phase_next = (word != 32'd0) ? bed_pkg::PH_KEY : bed_pkg::PH_VLEN;
                end
            end
            bed_pkg::PH_KEY:
            begin
                push_cmd.has_main              = 1'b1;
                push_cmd.main_res.kind         = bed_pkg::KIND_KEY;
                push_cmd.main_res.payload_byte = data_byte;
                rem_next                       = rem_dec;
                if (rem_dec == 32'd0)
                    phase_next = bed_pkg::PH_VLEN;
            end
            bed_pkg::PH_VLEN:
            begin
                if (full)
                begin
                    push_cmd.has_main      = 1'b1;
                    push_cmd.main_res.kind = bed_pkg::KIND_VLEN;
                    if (word == 32'd0)
                    begin
                        push_cmd.main_res.entry_end = 1'b1;
                        done                        = 1'b1;
                        phase_next                  = bed_pkg::PH_OP;
                    end
                    else
                    begin
                        push_cmd.main_res.length_value = word;
                        rem_next                       = word;
                        phase_next                     = bed_pkg::PH_VAL;
                    end
                end
            end
            bed_pkg::PH_VAL:
            begin
                push_cmd.has_main              = 1'b1;
                push_cmd.main_res.kind         = bed_pkg::KIND_VAL;
                push_cmd.main_res.payload_byte = data_byte;
                rem_next                       = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    push_cmd.main_res.entry_end = 1'b1;
                    done                        = 1'b1;
                    phase_next                  = bed_pkg::PH_OP;
                end
            end
            default:
            begin
                // a lone trailing byte is dropped
                if (!record_last)
                begin
                    held_op_next = data_byte;
                    cnt_next     = 2'd0;
                    asm_next     = 32'd0;
                    rem_next     = 32'd0;
                    phase_next   = bed_pkg::PH_SRV;
                end
            end
        endcase

        if (record_last && (phase_reg != bed_pkg::PH_OP))
        begin
            if (done)
                push_cmd.main_res.record_end = 1'b1;
            else
            begin
                // record ended mid-entry: error after the byte's own result
                push_cmd.has_err = 1'b1;
                phase_next       = bed_pkg::PH_OP;
                cnt_next         = 2'd0;
                asm_next         = 32'd0;
                rem_next         = 32'd0;
                held_op_next     = 8'd0;
                held_srv_next    = 32'd0;
                held_time_next   = 32'd0;
            end
        end
    end

    assign push = accept && (push_cmd.has_main || push_cmd.has_err);

endmodule

/* sv/bed_queue.sv */
// command queue between parser and output stage
`timescale 1ns / 1ps

module bed_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bed_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output bed_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bed_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

endmodule

/* sv/bed_back.sv */
// back end: expands queued commands into output words held in a register
`timescale 1ns / 1ps

module bed_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                not_empty,
    input  bed_pkg::cmd_t                       head_cmd,
    input  logic                                out_ready,
    output logic                                pop,
    output logic                                out_valid,
    output logic [bed_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic [bed_pkg::OUT_TUSER_W-1:0]     out_user,
    output logic                                out_last
);

    logic             out_valid_reg, out_valid_next;
    bed_pkg::result_t out_res_reg, out_res_next;
    logic             second_reg, second_next;

    always_comb
    begin
        logic             load;
        logic             use_main;
        bed_pkg::result_t err_res;

        err_res            = '0;
        err_res.kind       = bed_pkg::KIND_ERR;
        err_res.entry_end  = 1'b1;
        err_res.record_end = 1'b1;

        load     = not_empty && (!out_valid_reg || out_ready);
        use_main = head_cmd.has_main && !second_reg;

        out_res_next   = out_res_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = use_main ? head_cmd.main_res : err_res;
            // keep the entry when an error word still has to follow
            if (use_main && head_cmd.has_err)
                second_next = 1'b1;
            else
            begin
                second_next = 1'b0;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_res_reg.payload_byte, out_res_reg.length_value,
                        out_res_reg.exec_stamp, out_res_reg.server_ident,
                        out_res_reg.op_code};
    assign out_user  = {out_res_reg.entry_end, out_res_reg.kind};
    assign out_last  = out_res_reg.record_end;

endmodule

/* sv/bed_checker.sv */
// port-level checks for the binlog entry deframer, bound to the top level
`timescale 1ns / 1ps

module bed_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bed_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [bed_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input logic                             m_axis_tlast
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // end of record always closes the entry
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[3])
        else $error("record end without entry end");

    // error word closes record and entry with empty data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == bed_pkg::KIND_ERR) |->
            m_axis_tlast && m_axis_tuser[3] && (m_axis_tdata == '0))
        else $error("malformed truncation error word");

    // key bytes carry only the payload and never end an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == bed_pkg::KIND_KEY) |->
            (m_axis_tdata[103:0] == '0) && !m_axis_tuser[3])
        else $error("key byte word carries header data or entry end");

    // header never ends an entry or a record
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == bed_pkg::KIND_HDR) |->
            !m_axis_tuser[3] && !m_axis_tlast && (m_axis_tdata[111:104] == '0))
        else $error("header word flagged as end");

endmodule

bind binlog_entry_deframer_top bed_checker u_bed_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
